@@ hw/rtl/tmwf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmwf_pkg
// shared widths, defaults and the word type passed from front to back
// ----------------------------------------------------------------------------
package tmwf_pkg;

    localparam int DATA_W         = 12;
    localparam int MID_TAPS       = 4;
    localparam int SUM_W          = DATA_W + $clog2(MID_TAPS);
    localparam int WINDOW_LEN_DEF = 12;
    localparam int WARMUP_LEN_DEF = 13;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QLVL_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DATA_W-1:0] REJECT_RESET = '1;

    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic              dropped;
    } item_t;

endpackage
`default_nettype wire

@@ hw/rtl/tmwf_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmwf_front
// input stage: holds the reject level and tags each word as kept or dropped
// ----------------------------------------------------------------------------
module tmwf_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tmwf_pkg::DATA_W-1:0]    cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [tmwf_pkg::DATA_W-1:0]    sample,
    output logic                                st_valid,
    input  wire logic                           st_ready,
    output tmwf_pkg::item_t                     st_item
);
    import tmwf_pkg::*;

    logic [DATA_W-1:0] reject_level_reg;
    logic              valid_reg;
    logic              valid_next;
    item_t             item_reg;

    assign in_ready = !valid_reg || st_ready;
    assign st_valid = valid_reg;
    assign st_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (st_ready)
        begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reject_level_reg <= REJECT_RESET;
            valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                reject_level_reg <= cfg_wdata;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.sample  <= sample;
            item_reg.dropped <= (sample >= reject_level_reg);
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/tmwf_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmwf_queue
// short fifo between the input stage and the filter core
// ----------------------------------------------------------------------------
module tmwf_queue (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_valid,
    output logic                                wr_ready,
    input  wire tmwf_pkg::item_t                wr_item,
    output logic                                rd_valid,
    input  wire logic                           rd_ready,
    output tmwf_pkg::item_t                     rd_item,
    output logic [tmwf_pkg::QLVL_W-1:0]         level
);
    import tmwf_pkg::*;

    item_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QLVL_W-1:0]   level_reg;
    logic [QLVL_W-1:0]   level_next;
    logic                push;
    logic                pop;

    assign wr_ready = (level_reg != QLVL_W'(QUEUE_DEPTH));
    assign rd_valid = (level_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign level    = level_reg;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/tmwf_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmwf_back
// filter core: sample window, odd-even transposition sorter, middle-rank mean
// ----------------------------------------------------------------------------
module tmwf_back #(
    parameter int WINDOW_LEN = tmwf_pkg::WINDOW_LEN_DEF,
    parameter int WARMUP_LEN = tmwf_pkg::WARMUP_LEN_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_valid,
    output logic                                q_ready,
    input  wire tmwf_pkg::item_t                q_item,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [tmwf_pkg::DATA_W-1:0]         filtered,
    output logic                                dropped,
    output logic                                warming
);
    import tmwf_pkg::*;

    localparam int CNT_W  = $clog2(WARMUP_LEN + 1);
    localparam int PASS_W = $clog2(WINDOW_LEN);
    localparam int LO     = WINDOW_LEN / 2 - 2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [PASS_W-1:0]   pass_reg;
    logic [PASS_W-1:0]   pass_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [DATA_W-1:0]   held_reg;
    logic [DATA_W-1:0]   held_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [DATA_W-1:0]   res_reg;
    logic [DATA_W-1:0]   res_next;
    logic                drop_reg;
    logic                drop_next;
    logic                warm_reg;
    logic                warm_next;
    logic                out_load;

    // the oldest sample leaves the window as the new one enters
    logic [DATA_W-1:0]   win_reg  [WINDOW_LEN-1];
    logic [DATA_W-1:0]   srt_reg  [WINDOW_LEN];
    logic [DATA_W-1:0]   srt_step [WINDOW_LEN];

    logic                out_free;
    logic                pop;
    logic                in_warmup;
    logic                shift_en;
    logic                sort_load;
    logic [SUM_W-1:0]    mid_sum;
    logic [DATA_W-1:0]   mean;

    assign out_free  = !out_valid_reg || out_ready;
    assign q_ready   = (state_reg == ST_IDLE) && out_free;
    assign pop       = q_valid && q_ready;
    assign in_warmup = (cnt_reg < CNT_W'(WARMUP_LEN));
    assign shift_en  = pop && !q_item.dropped;
    assign sort_load = shift_en && !in_warmup;

    assign out_valid = out_valid_reg;
    assign filtered  = res_reg;
    assign dropped   = drop_reg;
    assign warming   = warm_reg;

    // one transposition pass, pairs alternate with the pass parity
    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            srt_step[i] = srt_reg[i];
        end
        for (int i = 0; i < WINDOW_LEN - 1; i++)
        begin
            if (1'(i & 1) == pass_reg[0])
            begin
                if (srt_reg[i] > srt_reg[i+1])
                begin
                    srt_step[i]   = srt_reg[i+1];
                    srt_step[i+1] = srt_reg[i];
                end
            end
        end
    end

    always_comb
    begin
        mid_sum = '0;
        for (int i = 0; i < MID_TAPS; i++)
        begin
            mid_sum = mid_sum + SUM_W'(srt_reg[LO+i]);
        end
        mean = mid_sum[SUM_W-1:SUM_W-DATA_W];
    end

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        cnt_next       = cnt_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;
        drop_next      = drop_reg;
        warm_next      = warm_reg;
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (q_item.dropped)
                    begin
                        out_load  = 1'b1;
                        res_next  = held_reg;
                        drop_next = 1'b1;
                        warm_next = 1'b0;
                    end
                    else if (in_warmup)
                    begin
                        out_load  = 1'b1;
                        cnt_next  = cnt_reg + 1'b1;
                        held_next = q_item.sample;
                        res_next  = q_item.sample;
                        drop_next = 1'b0;
                        warm_next = 1'b1;
                    end
                    else
                    begin
                        pass_next  = '0;
                        state_next = ST_SORT;
                    end
                end
            end
            ST_SORT:
            begin
                pass_next = pass_reg + 1'b1;
                if (pass_reg == PASS_W'(WINDOW_LEN - 1))
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    held_next  = mean;
                    res_next   = mean;
                    drop_next  = 1'b0;
                    warm_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= '0;
            cnt_reg       <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            cnt_reg       <= cnt_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        drop_reg <= drop_next;
        warm_reg <= warm_next;
        if (shift_en)
        begin
            win_reg[0] <= q_item.sample;
            for (int i = 1; i < WINDOW_LEN - 1; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
        end
        if (sort_load)
        begin
            srt_reg[0] <= q_item.sample;
            for (int i = 1; i < WINDOW_LEN; i++)
            begin
                srt_reg[i] <= win_reg[i-1];
            end
        end
        else if (state_reg == ST_SORT)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                srt_reg[i] <= srt_step[i];
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/trimmed_mean_window_filter_unit.sv @@
// each word passes the input register, the queue and the output register
// throughput: one word per cycle for dropped and warm-up words while out_ready is held;
// a filtered word needs the WINDOW_LEN sorter passes and the sum before the core takes another
// a two-word queue lets the input keep taking words while the sorter is busy
// reset: asynchronous active-low; clears warm-up count, held value and handshake state,
// reject level returns to full scale; window contents are not cleared
`default_nettype none
// ----------------------------------------------------------------------------
// trimmed_mean_window_filter_unit
// trimmed-mean filter over a sliding window of converter samples
// ----------------------------------------------------------------------------
module trimmed_mean_window_filter_unit #(
    parameter int WINDOW_LEN = tmwf_pkg::WINDOW_LEN_DEF,
    parameter int WARMUP_LEN = tmwf_pkg::WARMUP_LEN_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tmwf_pkg::DATA_W-1:0]    cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [tmwf_pkg::DATA_W-1:0]    sample,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [tmwf_pkg::DATA_W-1:0]         filtered,
    output logic                                dropped,
    output logic                                warming
);
    import tmwf_pkg::*;

    logic              st_valid;
    logic              st_ready;
    item_t             st_item;
    logic              q_valid;
    logic              q_ready;
    item_t             q_item;
    logic [QLVL_W-1:0] q_level;

    tmwf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .st_valid  (st_valid),
        .st_ready  (st_ready),
        .st_item   (st_item)
    );

    tmwf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (st_valid),
        .wr_ready (st_ready),
        .wr_item  (st_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item),
        .level    (q_level)
    );

    tmwf_back #(
        .WINDOW_LEN (WINDOW_LEN),
        .WARMUP_LEN (WARMUP_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .filtered  (filtered),
        .dropped   (dropped),
        .warming   (warming)
    );

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(dropped && warming))
        else $error("dropped and warming both set");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= QLVL_W'(QUEUE_DEPTH))
        else $error("queue level above depth");

    a_queue_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (q_level == '0) |-> !q_valid)
        else $error("queue presents a word while empty");
`endif

endmodule
`default_nettype wire
